>>> design/three_stacks_shared_memory_macros.svh
// Assertion macros for the three-stack block.
`ifndef THREE_STACKS_SHARED_MEMORY_MACROS_SVH
`define THREE_STACKS_SHARED_MEMORY_MACROS_SVH
`ifndef ASSERT_OFF
`define TSSM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TSSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);
`else
`define TSSM_ASSERT(lbl, clk, rst_n, prop, msg)
`define TSSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> design/tssm_pkg.sv
`timescale 1ns / 1ps
package tssm_pkg;

    localparam int unsigned DATA_W = 32;

    localparam logic       OP_PUSH = 1'b0;
    localparam logic       OP_POP  = 1'b1;

    localparam logic [1:0] SEL_A = 2'd0;
    localparam logic [1:0] SEL_B = 2'd1;
    localparam logic [1:0] SEL_C = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

>>> design/three_stacks_shared_memory.sv
`timescale 1ns / 1ps
// Channel  | Dir | tdata               | tuser
// s_axis   | in  | [31:0] push_value   | [0] opcode, [2:1] stack_sel
// m_axis   | out | [31:0] pop_value    | [1:0] status
//
// Push without a window move, push that reports full, pop that reports
// empty: result registered in the cycle after the transaction; a new one
// every cycle while results are taken. Pop: memory read registered, then the
// result in S_POPRD. Push that moves stack C's window: one read/write per moved entry.
// Reset (i_rst_n low, synchronous) empties all three stacks; memory keeps data.
// Input is held off while the result register holds an untaken result.
module three_stacks_shared_memory #(
    parameter int DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic signed [tssm_pkg::DATA_W-1:0] i_s_axis_tdata,  // [31:0] push_value
    input  logic [2:0]                         i_s_axis_tuser,  // [0] opcode, [2:1] stack_sel
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic signed [tssm_pkg::DATA_W-1:0] o_m_axis_tdata,  // [31:0] pop_value
    output logic [1:0]                         o_m_axis_tuser   // [1:0] status
);

`include "three_stacks_shared_memory_macros.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] P_ONE   = PW'(1);
    localparam logic [PW-1:0] P_ZERO  = PW'(0);
    localparam logic [PW-1:0] P_DEPTH = PW'(DEPTH);
    localparam logic [PW-1:0] P_MID   = PW'(DEPTH / 2);
    localparam logic [AW-1:0] A_ONE   = AW'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POPRD,
        S_MOVE
    } t_state;

    t_state                      r_state, n_state;
    logic [PW-1:0]               r_low, n_low;
    logic [PW-1:0]               r_start, n_start;
    logic [PW-1:0]               r_end, n_end;
    logic [PW-1:0]               r_hb, n_hb;      // high_top + 1
    logic [PW-1:0]               r_cnt, n_cnt;
    logic [AW-1:0]               r_src, n_src;
    logic [AW-1:0]               r_dst, n_dst;
    logic                        r_pend, n_pend;
    logic                        r_up, n_up;
    logic [1:0]                  r_sel, n_sel;
    logic [tssm_pkg::DATA_W-1:0] r_val, n_val;
    logic                        r_out_valid, n_out_valid;
    logic [tssm_pkg::DATA_W-1:0] r_out_pop, n_out_pop;
    tssm_pkg::t_status           r_out_status, n_out_status;

    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [tssm_pkg::DATA_W-1:0] ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [tssm_pkg::DATA_W-1:0] ram_rdata;

    logic                        in_acc;
    logic                        in_op;
    logic [1:0]                  in_sel;
    logic                        low_room;
    logic                        high_room;
    logic [PW-1:0]               low_m1;
    logic [PW-1:0]               end_m1;
    logic [PW-1:0]               hb_m1;
    logic                        start_move;

    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign in_op           = i_s_axis_tuser[0];
    assign in_sel          = i_s_axis_tuser[2:1];
    assign low_room        = r_low < r_start;
    assign high_room       = r_end < r_hb;
    assign low_m1          = r_low - P_ONE;
    assign end_m1          = r_end - P_ONE;
    assign hb_m1           = r_hb - P_ONE;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_pop;
    assign o_m_axis_tuser  = r_out_status;

    tssm_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_low        = r_low;
        n_start      = r_start;
        n_end        = r_end;
        n_hb         = r_hb;
        n_cnt        = r_cnt;
        n_src        = r_src;
        n_dst        = r_dst;
        n_pend       = 1'b0;
        n_up         = r_up;
        n_sel        = r_sel;
        n_val        = r_val;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_pop    = r_out_pop;
        n_out_status = r_out_status;
        ram_we       = 1'b0;
        ram_waddr    = r_low[AW-1:0];
        ram_wdata    = i_s_axis_tdata;
        ram_raddr    = r_src;
        start_move   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_out_pop    = '0;
                    n_out_status = tssm_pkg::ST_OK;
                    n_out_valid  = 1'b1;
                    if (in_op == tssm_pkg::OP_PUSH) begin
                        priority if (in_sel == tssm_pkg::SEL_A) begin
                            if (low_room) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_low[AW-1:0];
                                n_low     = r_low + P_ONE;
                            end else if (high_room) begin
                                start_move = 1'b1;
                            end else begin
                                n_out_status = tssm_pkg::ST_FULL;
                            end
                        end else if (in_sel == tssm_pkg::SEL_B) begin
                            if (high_room) begin
                                ram_we    = 1'b1;
                                ram_waddr = hb_m1[AW-1:0];
                                n_hb      = hb_m1;
                            end else if (low_room) begin
                                start_move = 1'b1;
                            end else begin
                                n_out_status = tssm_pkg::ST_FULL;
                            end
                        end else if (in_sel == tssm_pkg::SEL_C) begin
                            if (high_room) begin
                                ram_we    = 1'b1;
                                ram_waddr = r_end[AW-1:0];
                                n_end     = r_end + P_ONE;
                            end else if (low_room) begin
                                start_move = 1'b1;
                            end else begin
                                n_out_status = tssm_pkg::ST_FULL;
                            end
                        end else begin
                            n_out_status = tssm_pkg::ST_FULL;
                        end
                    end else begin
                        priority if (in_sel == tssm_pkg::SEL_A && r_low != P_ZERO) begin
                            ram_raddr   = low_m1[AW-1:0];
                            n_low       = low_m1;
                            n_out_valid = 1'b0;
                            n_state     = S_POPRD;
                        end else if (in_sel == tssm_pkg::SEL_B && r_hb != P_DEPTH) begin
                            ram_raddr   = r_hb[AW-1:0];
                            n_hb        = r_hb + P_ONE;
                            n_out_valid = 1'b0;
                            n_state     = S_POPRD;
                        end else if (in_sel == tssm_pkg::SEL_C && r_end != r_start) begin
                            ram_raddr   = end_m1[AW-1:0];
                            n_end       = end_m1;
                            n_out_valid = 1'b0;
                            n_state     = S_POPRD;
                        end else begin
                            n_out_status = tssm_pkg::ST_EMPTY;
                        end
                    end
                    if (start_move) begin
                        n_out_valid = 1'b0;
                        n_state     = S_MOVE;
                        n_sel       = in_sel;
                        n_val       = i_s_axis_tdata;
                        n_up        = (in_sel == tssm_pkg::SEL_A);
                        n_cnt       = r_end - r_start;
                        n_src       = (in_sel == tssm_pkg::SEL_A) ? end_m1[AW-1:0]
                                                                : r_start[AW-1:0];
                    end
                end
            end
            S_POPRD: begin
                n_out_valid  = 1'b1;
                n_out_pop    = ram_rdata;
                n_out_status = tssm_pkg::ST_OK;
                n_state      = S_IDLE;
            end
            S_MOVE: begin
                ram_raddr = r_src;
                ram_we    = r_pend;
                ram_waddr = r_dst;
                ram_wdata = ram_rdata;
                if (r_cnt != P_ZERO) begin
                    n_pend = 1'b1;
                    n_cnt  = r_cnt - P_ONE;
                    n_dst  = r_up ? (r_src + A_ONE) : (r_src - A_ONE);
                    n_src  = r_up ? (r_src - A_ONE) : (r_src + A_ONE);
                end else if (!r_pend) begin
                    ram_we       = 1'b1;
                    ram_wdata    = r_val;
                    n_out_valid  = 1'b1;
                    n_out_pop    = '0;
                    n_out_status = tssm_pkg::ST_OK;
                    n_state      = S_IDLE;
                    priority if (r_sel == tssm_pkg::SEL_A) begin
                        ram_waddr = r_low[AW-1:0];
                        n_low     = r_low + P_ONE;
                        n_start   = r_start + P_ONE;
                        n_end     = r_end + P_ONE;
                    end else if (r_sel == tssm_pkg::SEL_B) begin
                        ram_waddr = hb_m1[AW-1:0];
                        n_hb      = hb_m1;
                        n_start   = r_start - P_ONE;
                        n_end     = end_m1;
                    end else begin
                        ram_waddr = end_m1[AW-1:0];
                        n_start   = r_start - P_ONE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_low       <= P_ZERO;
            r_start     <= P_MID;
            r_end       <= P_MID;
            r_hb        <= P_DEPTH;
            r_cnt       <= P_ZERO;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_low       <= n_low;
            r_start     <= n_start;
            r_end       <= n_end;
            r_hb        <= n_hb;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_src        <= n_src;
        r_dst        <= n_dst;
        r_up         <= n_up;
        r_sel        <= n_sel;
        r_val        <= n_val;
        r_out_pop    <= n_out_pop;
        r_out_status <= n_out_status;
    end

    `TSSM_ASSERT(a_order, i_clk, i_rst_n, r_low <= r_start && r_start <= r_end && r_end <= r_hb && r_hb <= P_DEPTH, "stack bounds out of order")
    `TSSM_ASSERT(a_move_out_empty, i_clk, i_rst_n, r_state == S_MOVE |-> !r_out_valid, "result pending during window move")
    `TSSM_ASSERT_NEXT(a_pop_result, i_clk, i_rst_n, r_state == S_POPRD, r_out_valid && r_out_status == tssm_pkg::ST_OK, "pop read gave no result")
    `TSSM_ASSERT(a_zero_on_fail, i_clk, i_rst_n, r_out_valid && r_out_status != tssm_pkg::ST_OK |-> r_out_pop == '0, "nonzero data on failed transaction")

endmodule

>>> design/tssm_ram.sv
`timescale 1ns / 1ps
module tssm_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic [AW-1:0]                     i_waddr,
    input  logic [tssm_pkg::DATA_W-1:0]       i_wdata,
    input  logic [AW-1:0]                     i_raddr,
    output logic [tssm_pkg::DATA_W-1:0]       o_rdata
);

    logic [tssm_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [tssm_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
